// File: rtl/utf8wd_pkg.sv
// ----------------------------------------------------------------------------
// utf8wd_pkg
// Shared widths, byte-pattern constants and the space-character lookup for
// the UTF-8 whitespace opcode decoder.
// ----------------------------------------------------------------------------
package utf8wd_pkg;

    localparam int unsigned CP_W     = 21;
    localparam int unsigned OP_W     = 4;
    localparam int unsigned PEND_W   = 2;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned S_USER_W = 1;
    localparam int unsigned M_DATA_W = 32;
    localparam int unsigned M_USER_W = 2;

    // Input kind codes
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // Lead and continuation byte patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_VAL  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_VAL   = 8'h80;

    // Mapped space characters
    localparam logic [CP_W-1:0] CP_IDEO_SPACE = 21'h003000;
    localparam logic [CP_W-1:0] CP_SPACE_BASE = 21'h002000;

    // Opcodes
    localparam logic [OP_W-1:0] OP_RIGHT = 4'd0;
    localparam logic [OP_W-1:0] OP_LEFT  = 4'd1;
    localparam logic [OP_W-1:0] OP_INC   = 4'd2;
    localparam logic [OP_W-1:0] OP_DEC   = 4'd3;
    localparam logic [OP_W-1:0] OP_OUT   = 4'd4;
    localparam logic [OP_W-1:0] OP_IN    = 4'd5;
    localparam logic [OP_W-1:0] OP_OPEN  = 4'd6;
    localparam logic [OP_W-1:0] OP_CLOSE = 4'd7;
    localparam logic [OP_W-1:0] OP_NOP   = 4'd8;

    typedef struct packed {
        logic            is_token;
        logic [OP_W-1:0] opcode;
    } token_t;

    // Map a code point to its token flag and opcode
    function automatic token_t token_lookup(input logic [CP_W-1:0] cp);
        token_t tok;
        tok.is_token = 1'b0;
        tok.opcode   = OP_RIGHT;
        if (cp == CP_IDEO_SPACE) begin
            tok.is_token = 1'b1;
            tok.opcode   = OP_RIGHT;
        end else if (cp[CP_W-1:3] == CP_SPACE_BASE[CP_W-1:3]) begin
            tok.is_token = 1'b1;
            tok.opcode   = {1'b0, cp[2:0]} + OP_LEFT;
        end
        return tok;
    endfunction

endpackage

// File: rtl/utf8_whitespace_opcode_decoder.sv
// ----------------------------------------------------------------------------
// utf8_whitespace_opcode_decoder
// Byte-stream UTF-8 decoder that flags nine space characters as opcodes.
// ----------------------------------------------------------------------------
// Path: input register, then decode into the result register.
// Throughput: one byte per cycle unless a stalled result holds the input;
//   the decode state updates in a single pass.
// Reset: aresetn, synchronous active low, empties both registers and returns
//   the decoder to idle with a cleared accumulator.
module utf8_whitespace_opcode_decoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: [7:0] data_byte
    input  logic [utf8wd_pkg::S_DATA_W-1:0] s_tdata,
    // s_tuser: [0] kind
    input  logic [utf8wd_pkg::S_USER_W-1:0] s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata: [20:0] codepoint, [24:21] opcode, [31:25] zero
    output logic [utf8wd_pkg::M_DATA_W-1:0] m_tdata,
    // m_tuser: [0] is_token, [1] malformed
    output logic [utf8wd_pkg::M_USER_W-1:0] m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready
);
    import utf8wd_pkg::*;

    logic              in_valid_reg;
    logic              in_kind_reg;
    logic [7:0]        in_byte_reg;

    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [CP_W-1:0]   part_reg, part_next;

    logic              out_valid_reg;
    logic [CP_W-1:0]   out_cp_reg, out_cp_next;
    logic              out_tok_reg;
    logic [OP_W-1:0]   out_op_reg;
    logic              out_bad_reg, out_bad_next;

    logic              emit;
    logic              out_free;
    logic              consume;
    logic [CP_W-1:0]   shifted;
    token_t            tok;

    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Capture the request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_kind_reg <= s_tuser[0];
            in_byte_reg <= s_tdata[7:0];
        end
    end

    assign shifted = {part_reg[CP_W-7:0], in_byte_reg[5:0]};

    // Decode one byte against the pending state
    always_comb begin
        pend_next    = pend_reg;
        part_next    = part_reg;
        emit         = 1'b0;
        out_cp_next  = '0;
        out_bad_next = 1'b0;
        if (in_kind_reg == KIND_EOS) begin
            if (pend_reg != '0) begin
                emit         = 1'b1;
                out_bad_next = 1'b1;
                pend_next    = '0;
                part_next    = '0;
            end
        end else if (pend_reg == '0) begin
            priority if (!in_byte_reg[7]) begin
                emit        = 1'b1;
                out_cp_next = {{(CP_W-8){1'b0}}, in_byte_reg};
                part_next   = '0;
            end else if ((in_byte_reg & LEAD2_MASK) == LEAD2_VAL) begin
                pend_next = 2'd1;
                part_next = {{(CP_W-5){1'b0}}, in_byte_reg[4:0]};
            end else if ((in_byte_reg & LEAD3_MASK) == LEAD3_VAL) begin
                pend_next = 2'd2;
                part_next = {{(CP_W-4){1'b0}}, in_byte_reg[3:0]};
            end else if ((in_byte_reg & LEAD4_MASK) == LEAD4_VAL) begin
                pend_next = 2'd3;
                part_next = {{(CP_W-3){1'b0}}, in_byte_reg[2:0]};
            end else begin
                emit         = 1'b1;
                out_bad_next = 1'b1;
                part_next    = '0;
            end
        end else if ((in_byte_reg & CONT_MASK) != CONT_VAL) begin
            emit         = 1'b1;
            out_bad_next = 1'b1;
            pend_next    = '0;
            part_next    = '0;
        end else begin
            pend_next = pend_reg - 2'd1;
            if (pend_reg == 2'd1) begin
                emit        = 1'b1;
                out_cp_next = shifted;
                part_next   = '0;
            end else begin
                part_next = shifted;
            end
        end
    end

    assign tok = token_lookup(out_cp_next);

    // Advance decode state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            part_reg <= '0;
        end else if (consume) begin
            pend_reg <= pend_next;
            part_reg <= part_next;
        end
    end

    // Load or drain the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= consume && emit;
        end
        if (consume && emit) begin
            out_cp_reg  <= out_cp_next;
            out_tok_reg <= tok.is_token;
            out_op_reg  <= tok.opcode;
            out_bad_reg <= out_bad_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-CP_W-OP_W){1'b0}}, out_op_reg, out_cp_reg};
    assign m_tuser  = {out_bad_reg, out_tok_reg};

endmodule

// File: rtl/utf8wd_checker.sv
// ----------------------------------------------------------------------------
// utf8wd_checker
// Port-level checks on the input and result handshakes of the decoder, bound to the top.
// ----------------------------------------------------------------------------
module utf8wd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [utf8wd_pkg::M_DATA_W-1:0] m_tdata,
    input logic [utf8wd_pkg::M_USER_W-1:0] m_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready
);
    import utf8wd_pkg::*;

    logic [CP_W-1:0] cp;
    logic [OP_W-1:0] op;
    token_t          tok_exp;
    assign cp      = m_tdata[CP_W-1:0];
    assign op      = m_tdata[CP_W+OP_W-1:CP_W];
    assign tok_exp = token_lookup(cp);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Error results carry no code point and no token
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> cp == '0 && !m_tuser[0] && op == OP_RIGHT)
        else $error("malformed result with payload");

    // Opcode matches the code point for tokens, else zero
    a_tok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> op == tok_exp.opcode && m_tuser[0] == tok_exp.is_token
                  || m_tuser[1])
        else $error("token mapping mismatch");

    // No idle result stage stalls the input side
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result stage");

    // A result never appears without an accepted request to produce it
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!m_tvalid) && $past(!s_tvalid || !s_tready, 2) && $past(!m_tvalid, 2)
        && $past(aresetn, 2) |-> !m_tvalid)
        else $error("result without a request");

endmodule

bind utf8_whitespace_opcode_decoder utf8wd_checker u_utf8wd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
